FILE: rtl/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg
// Types, constants and helpers shared by the angle/bias Kalman filter core.
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int COV_FRAC_BITS = 32;
    localparam int NOISE_FRAC    = 28;
    localparam int COV_W         = 48;
    localparam int ANG_W         = 32;

    // sequential multiplier geometry
    localparam int MUL_A_W   = 56;
    localparam int MUL_B_W   = 48;
    localparam int MUL_DIG_W = 16;
    localparam int MUL_ACC_W = MUL_A_W + MUL_B_W;

    // restoring divider geometry
    localparam int DIV_W   = COV_W + COV_FRAC_BITS;
    localparam int DIV_CNT = $clog2(DIV_W);

    localparam logic signed [COV_W-1:0] COV_ONE = COV_W'(1) << COV_FRAC_BITS;
    localparam logic signed [COV_W-1:0] MAX48   = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic signed [COV_W-1:0] MIN48   = {1'b1, {(COV_W-1){1'b0}}};
    localparam logic signed [ANG_W-1:0] MAX32   = {1'b0, {(ANG_W-1){1'b1}}};
    localparam logic signed [ANG_W-1:0] MIN32   = {1'b1, {(ANG_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [1:0] CFG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] CFG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] CFG_MEASURE_NOISE = 2'd2;

    // datapath operation sequence
    localparam logic [3:0] OP_ANG   = 4'd0;
    localparam logic [3:0] OP_DTP11 = 4'd1;
    localparam logic [3:0] OP_P00   = 4'd2;
    localparam logic [3:0] OP_P11   = 4'd3;
    localparam logic [3:0] OP_DIV0  = 4'd4;
    localparam logic [3:0] OP_DIV1  = 4'd5;
    localparam logic [3:0] OP_K1P00 = 4'd6;
    localparam logic [3:0] OP_K0P00 = 4'd7;
    localparam logic [3:0] OP_K1P01 = 4'd8;
    localparam logic [3:0] OP_K0P01 = 4'd9;
    localparam logic [3:0] OP_K0Y   = 4'd10;
    localparam logic [3:0] OP_K1Y   = 4'd11;

    typedef struct packed {
        logic               command;
        logic signed [31:0] meas_angle;
        logic signed [31:0] turn_rate;
        logic [31:0]        time_step;
        logic signed [31:0] start_angle;
    } t_in;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] bias_estimate;
    } t_out;

    typedef struct packed {
        logic       load;
        logic [3:0] op;
        logic       mul_start;
        logic       div_start;
        logic       wb;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_sts;

    function automatic logic signed [63:0] f_noise(logic [31:0] v);
        logic [63:0] w;
        w = {32'b0, v};
        if (COV_FRAC_BITS >= NOISE_FRAC) begin
            f_noise = w << (COV_FRAC_BITS - NOISE_FRAC);
        end else begin
            f_noise = (w + (64'd1 << (NOISE_FRAC - COV_FRAC_BITS - 1)))
                      >> (NOISE_FRAC - COV_FRAC_BITS);
        end
    endfunction

    function automatic logic signed [64:0] f_sx32(logic signed [31:0] v);
        f_sx32 = {{33{v[31]}}, v};
    endfunction

    function automatic logic signed [64:0] f_sx48(logic signed [47:0] v);
        f_sx48 = {{17{v[47]}}, v};
    endfunction

    function automatic logic signed [64:0] f_sx64(logic signed [63:0] v);
        f_sx64 = {v[63], v};
    endfunction

    function automatic logic signed [31:0] f_sat32(logic signed [64:0] x);
        if (x > f_sx32(MAX32)) f_sat32 = MAX32;
        else if (x < f_sx32(MIN32)) f_sat32 = MIN32;
        else f_sat32 = x[31:0];
    endfunction

    function automatic logic signed [47:0] f_sat48(logic signed [64:0] x);
        if (x > f_sx48(MAX48)) f_sat48 = MAX48;
        else if (x < f_sx48(MIN48)) f_sat48 = MIN48;
        else f_sat48 = x[47:0];
    endfunction

endpackage

FILE: rtl/kabf_mul.sv
// ----------------------------------------------------------------------------
// kabf_mul
// Digit-serial signed multiplier: 16 bits of B per cycle, then a rounded
// right shift (ties away from zero) by the noise or covariance fraction.
// ----------------------------------------------------------------------------
module kabf_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_cov_shift,
    input  logic signed [63:0] i_a,
    input  logic signed [48:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    localparam logic [kabf_pkg::MUL_ACC_W:0] RND_COV =
        (kabf_pkg::MUL_ACC_W+1)'(1) << (kabf_pkg::COV_FRAC_BITS - 1);
    localparam logic [kabf_pkg::MUL_ACC_W:0] RND_NOISE =
        (kabf_pkg::MUL_ACC_W+1)'(1) << (kabf_pkg::NOISE_FRAC - 1);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [1:0]                        r_cnt, n_cnt;
    logic [kabf_pkg::MUL_A_W-1:0]      r_am, n_am;
    logic [kabf_pkg::MUL_B_W-1:0]      r_bm, n_bm;
    logic                              r_neg, n_neg;
    logic                              r_sh, n_sh;
    logic [kabf_pkg::MUL_ACC_W-1:0]    r_acc, n_acc;
    logic signed [63:0]                r_res, n_res;

    logic [63:0]                       w_amag;
    logic [48:0]                       w_bmag;
    logic [kabf_pkg::MUL_B_W-1:0]      w_bsh;
    logic [kabf_pkg::MUL_DIG_W-1:0]    w_dig;
    logic [kabf_pkg::MUL_A_W+kabf_pkg::MUL_DIG_W-1:0] w_pp;
    logic [kabf_pkg::MUL_ACC_W-1:0]    w_pps;
    logic [kabf_pkg::MUL_ACC_W:0]      w_rnd, w_shr;

    always_comb begin
        w_amag = i_a[63] ? 64'(-i_a) : 64'(i_a);
        w_bmag = i_b[48] ? 49'(-i_b) : 49'(i_b);
        w_bsh  = r_bm >> {r_cnt, 4'b0};
        w_dig  = w_bsh[kabf_pkg::MUL_DIG_W-1:0];
        w_pp   = r_am * w_dig;
        w_pps  = kabf_pkg::MUL_ACC_W'(w_pp) << {r_cnt, 4'b0};
        w_rnd  = {1'b0, r_acc} + (r_sh ? RND_COV : RND_NOISE);
        w_shr  = r_sh ? (w_rnd >> kabf_pkg::COV_FRAC_BITS) : (w_rnd >> kabf_pkg::NOISE_FRAC);

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_am   = r_am;
        n_bm   = r_bm;
        n_neg  = r_neg;
        n_sh   = r_sh;
        n_acc  = r_acc;
        n_res  = r_res;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 2'd0;
            n_am   = w_amag[kabf_pkg::MUL_A_W-1:0];
            n_bm   = w_bmag[kabf_pkg::MUL_B_W-1:0];
            n_neg  = i_a[63] ^ i_b[48];
            n_sh   = i_cov_shift;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_cnt == 2'd3) begin
                // round, scale and restore the sign
                n_busy = 1'b0;
                n_done = 1'b1;
                n_res  = r_neg ? -$signed(w_shr[63:0]) : $signed(w_shr[63:0]);
            end else begin
                n_acc = r_acc + w_pps;
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_am  <= n_am;
        r_bm  <= n_bm;
        r_neg <= n_neg;
        r_sh  <= n_sh;
        r_acc <= n_acc;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: rtl/kabf_div.sv
// ----------------------------------------------------------------------------
// kabf_div
// Restoring divider for the gains: (num << COV_FRAC_BITS) / den, one
// quotient bit per cycle, rounded half away from zero, saturated to 48 bits.
// ----------------------------------------------------------------------------
module kabf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [47:0] i_num,
    input  logic [47:0]        i_den,
    output logic               o_done,
    output logic signed [47:0] o_q
);

    localparam logic [kabf_pkg::DIV_CNT-1:0] LAST = kabf_pkg::DIV_CNT'(kabf_pkg::DIV_W - 1);

    logic                             r_busy, n_busy;
    logic                             r_fin, n_fin;
    logic                             r_done, n_done;
    logic [kabf_pkg::DIV_CNT-1:0]     r_cnt, n_cnt;
    logic [kabf_pkg::DIV_W-1:0]       r_dvd, n_dvd;
    logic [kabf_pkg::DIV_W-1:0]       r_q, n_q;
    logic [47:0]                      r_rem, n_rem;
    logic [47:0]                      r_d, n_d;
    logic                             r_neg, n_neg;
    logic signed [47:0]               r_res, n_res;

    logic [47:0]                      w_nmag;
    logic [48:0]                      w_rs, w_sub;
    logic                             w_ge, w_up;
    logic [kabf_pkg::DIV_W-1:0]       w_qs;
    logic [47:0]                      w_qm;

    always_comb begin
        w_nmag = i_num[47] ? 48'(-i_num) : 48'(i_num);
        w_rs   = {r_rem, r_dvd[kabf_pkg::DIV_W-1]};
        w_sub  = w_rs - {1'b0, r_d};
        w_ge   = w_rs >= {1'b0, r_d};
        w_up   = {r_rem, 1'b0} >= {1'b0, r_d};
        w_qs   = r_q + kabf_pkg::DIV_W'(w_up);
        if (r_q > kabf_pkg::DIV_W'(kabf_pkg::MAX48) ||
            w_qs > kabf_pkg::DIV_W'(kabf_pkg::MAX48)) begin
            w_qm = kabf_pkg::MAX48;
        end else begin
            w_qm = w_qs[47:0];
        end

        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        n_neg  = r_neg;
        n_res  = r_res;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = {w_nmag, kabf_pkg::COV_FRAC_BITS'(0)};
            n_q    = '0;
            n_rem  = '0;
            n_d    = i_den;
            n_neg  = i_num[47];
        end else if (r_busy) begin
            n_rem = w_ge ? w_sub[47:0] : w_rs[47:0];
            n_q   = {r_q[kabf_pkg::DIV_W-2:0], w_ge};
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end else if (r_fin) begin
            n_done = 1'b1;
            n_res  = r_neg ? -$signed(w_qm) : $signed(w_qm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_q    = r_res;

endmodule

FILE: rtl/kabf_datapath.sv
// ----------------------------------------------------------------------------
// kabf_datapath
// Filter state, noise registers, operand selection for the shared multiplier
// and divider, and the write-back of each step of the predict/correct pass.
// ----------------------------------------------------------------------------
module kabf_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kabf_pkg::t_in        i_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  kabf_pkg::t_cmd       i_cmd,
    output kabf_pkg::t_sts       o_sts,
    output kabf_pkg::t_out       o_data
);

    logic [31:0]        r_qa, r_qb, r_rm;
    logic signed [31:0] r_angle, r_bias, r_meas;
    logic [31:0]        r_dt;
    logic signed [32:0] r_rb, r_y;
    logic signed [47:0] r_p00, r_p01, r_p10, r_p11;
    logic signed [47:0] r_k0, r_k1;
    logic signed [63:0] r_inner;
    logic signed [48:0] r_s;
    kabf_pkg::t_out     r_out;

    logic signed [63:0] w_qa, w_qb, w_rm;
    logic signed [63:0] w_a, w_res;
    logic signed [48:0] w_b;
    logic               w_cov_sh;
    logic signed [47:0] w_num, w_q;
    logic               w_s_pos;

    always_comb begin
        w_qa = kabf_pkg::f_noise(r_qa);
        w_qb = kabf_pkg::f_noise(r_qb);
        w_rm = kabf_pkg::f_noise(r_rm);
        w_s_pos = !r_s[48] && (r_s != '0);
        w_num = (i_cmd.op == kabf_pkg::OP_DIV1) ? r_p10 : r_p00;

        w_a = '0;
        w_b = '0;
        w_cov_sh = 1'b1;
        case (i_cmd.op)
            kabf_pkg::OP_ANG: begin
                w_a = {{31{r_rb[32]}}, r_rb};
                w_b = {17'b0, r_dt};
                w_cov_sh = 1'b0;
            end
            kabf_pkg::OP_DTP11: begin
                w_a = {{16{r_p11[47]}}, r_p11};
                w_b = {17'b0, r_dt};
                w_cov_sh = 1'b0;
            end
            kabf_pkg::OP_P00: begin
                w_a = r_inner;
                w_b = {17'b0, r_dt};
                w_cov_sh = 1'b0;
            end
            kabf_pkg::OP_P11: begin
                w_a = w_qb;
                w_b = {17'b0, r_dt};
                w_cov_sh = 1'b0;
            end
            kabf_pkg::OP_K1P00: begin
                w_a = {{16{r_p00[47]}}, r_p00};
                w_b = {r_k1[47], r_k1};
            end
            kabf_pkg::OP_K0P00: begin
                w_a = {{16{r_p00[47]}}, r_p00};
                w_b = {r_k0[47], r_k0};
            end
            kabf_pkg::OP_K1P01: begin
                w_a = {{16{r_p01[47]}}, r_p01};
                w_b = {r_k1[47], r_k1};
            end
            kabf_pkg::OP_K0P01: begin
                w_a = {{16{r_p01[47]}}, r_p01};
                w_b = {r_k0[47], r_k0};
            end
            kabf_pkg::OP_K0Y: begin
                w_a = {{16{r_k0[47]}}, r_k0};
                w_b = {{16{r_y[32]}}, r_y};
            end
            kabf_pkg::OP_K1Y: begin
                w_a = {{16{r_k1[47]}}, r_k1};
                w_b = {{16{r_y[32]}}, r_y};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    kabf_mul u_mul (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.mul_start),
        .i_cov_shift (w_cov_sh),
        .i_a         (w_a),
        .i_b         (w_b),
        .o_done      (o_sts.mul_done),
        .o_res       (w_res)
    );

    kabf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_s[47:0]),
        .o_done  (o_sts.div_done),
        .o_q     (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa    <= 32'd268435;
            r_qb    <= 32'd805306;
            r_rm    <= 32'd8053064;
            r_angle <= '0;
            r_bias  <= '0;
            r_p00   <= kabf_pkg::COV_ONE;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= kabf_pkg::COV_ONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kabf_pkg::CFG_ANGLE_NOISE:   r_qa <= i_cfg_data;
                    kabf_pkg::CFG_BIAS_NOISE:    r_qb <= i_cfg_data;
                    kabf_pkg::CFG_MEASURE_NOISE: r_rm <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load && i_data.command) begin
                r_angle <= i_data.start_angle;
                r_bias  <= '0;
                r_p00   <= kabf_pkg::COV_ONE;
                r_p01   <= '0;
                r_p10   <= '0;
                r_p11   <= kabf_pkg::COV_ONE;
            end
            if (i_cmd.wb) begin
                case (i_cmd.op)
                    kabf_pkg::OP_ANG:
                        r_angle <= kabf_pkg::f_sat32(kabf_pkg::f_sx32(r_angle)
                                                     + kabf_pkg::f_sx64(w_res));
                    kabf_pkg::OP_DTP11: begin
                        // old off-diagonals feed the inner term
                        r_p01 <= kabf_pkg::f_sat48(kabf_pkg::f_sx48(r_p01)
                                                   - kabf_pkg::f_sx64(w_res));
                        r_p10 <= kabf_pkg::f_sat48(kabf_pkg::f_sx48(r_p10)
                                                   - kabf_pkg::f_sx64(w_res));
                    end
                    kabf_pkg::OP_P00:
                        r_p00 <= kabf_pkg::f_sat48(kabf_pkg::f_sx48(r_p00)
                                                   + kabf_pkg::f_sx64(w_res));
                    kabf_pkg::OP_P11:
                        r_p11 <= kabf_pkg::f_sat48(kabf_pkg::f_sx48(r_p11)
                                                   + kabf_pkg::f_sx64(w_res));
                    kabf_pkg::OP_K1P00:
                        r_p10 <= kabf_pkg::f_sat48(kabf_pkg::f_sx48(r_p10)
                                                   - kabf_pkg::f_sx64(w_res));
                    kabf_pkg::OP_K0P00:
                        r_p00 <= kabf_pkg::f_sat48(kabf_pkg::f_sx48(r_p00)
                                                   - kabf_pkg::f_sx64(w_res));
                    kabf_pkg::OP_K1P01:
                        r_p11 <= kabf_pkg::f_sat48(kabf_pkg::f_sx48(r_p11)
                                                   - kabf_pkg::f_sx64(w_res));
                    kabf_pkg::OP_K0P01:
                        r_p01 <= kabf_pkg::f_sat48(kabf_pkg::f_sx48(r_p01)
                                                   - kabf_pkg::f_sx64(w_res));
                    kabf_pkg::OP_K0Y:
                        r_angle <= kabf_pkg::f_sat32(kabf_pkg::f_sx32(r_angle)
                                                     + kabf_pkg::f_sx64(w_res));
                    kabf_pkg::OP_K1Y:
                        r_bias <= kabf_pkg::f_sat32(kabf_pkg::f_sx32(r_bias)
                                                    + kabf_pkg::f_sx64(w_res));
                    default: ;
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas <= i_data.meas_angle;
            r_dt   <= i_data.time_step;
            r_rb   <= {i_data.turn_rate[31], i_data.turn_rate} - {r_bias[31], r_bias};
        end
        if (i_cmd.wb) begin
            case (i_cmd.op)
                kabf_pkg::OP_DTP11:
                    r_inner <= w_res - {{16{r_p01[47]}}, r_p01}
                               - {{16{r_p10[47]}}, r_p10} + w_qa;
                kabf_pkg::OP_P11: begin
                    // p00 is already predicted here
                    r_s <= {r_p00[47], r_p00} + w_rm[48:0];
                    r_y <= {r_meas[31], r_meas} - {r_angle[31], r_angle};
                end
                kabf_pkg::OP_DIV0: r_k0 <= w_s_pos ? w_q : '0;
                kabf_pkg::OP_DIV1: r_k1 <= w_s_pos ? w_q : '0;
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.angle_estimate <= r_angle;
            r_out.bias_estimate  <= r_bias;
        end
    end

    assign o_data = r_out;

endmodule

FILE: rtl/kabf_ctrl.sv
// ----------------------------------------------------------------------------
// kabf_ctrl
// Sequencer: accepts a word, steps the datapath through the predict and
// correct operations for an update word, and loads the output register.
// ----------------------------------------------------------------------------
module kabf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_cmd_reset,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  kabf_pkg::t_sts  i_sts,
    output kabf_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_ov, n_ov;
    logic       w_is_div;

    always_comb begin
        w_is_div = (r_step == kabf_pkg::OP_DIV0) || (r_step == kabf_pkg::OP_DIV1);
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.op = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = kabf_pkg::OP_ANG;
                    n_state    = i_cmd_reset ? S_OUT : S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.mul_start = !w_is_div;
                o_cmd.div_start = w_is_div;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.mul_done || i_sts.div_done) begin
                    o_cmd.wb = 1'b1;
                    if (r_step == kabf_pkg::OP_K1Y) begin
                        n_state = S_OUT;
                    end else begin
                        n_step  = r_step + 4'd1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ov || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ov = o_cmd.out_load || (r_ov && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= kabf_pkg::OP_ANG;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ov    <= n_ov;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;

endmodule

FILE: rtl/kalman_angle_bias_filter_core.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_core
// Two-state (angle, gyro bias) Kalman filter in fixed point.
// ----------------------------------------------------------------------------
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  input    | i_valid / o_stall  | i_data  (command, angles, rate, time step)
//  output   | o_valid / i_stall  | o_data  (angle and bias estimates)
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// An update word runs from acceptance through ten products on the shared
// 56x16 digit-serial multiplier and two gains on the one-bit-per-cycle
// divider to the output load; a reset word goes from acceptance straight
// to the output load. One word is in work at a time and o_stall is high
// until its output load, which waits while a full output register is
// stalled. Reset is synchronous, active low, and restores the noise
// registers, zero angle and bias, and identity covariance.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  kabf_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output kabf_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data
);

    kabf_pkg::t_cmd w_cmd;
    kabf_pkg::t_sts w_sts;

    kabf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cmd_reset (i_data.command),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    kabf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_data     (o_data)
    );

    a_one_unit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sts.mul_done && w_sts.div_done))
        else $error("multiplier and divider finished together");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.mul_start, w_cmd.div_start, w_cmd.wb, w_cmd.out_load}))
        else $error("more than one datapath command at once");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_valid)
        else $error("output register loaded but not valid");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (i_valid && !o_stall))
        else $error("word captured without a handshake");

endmodule

FILE: bench/kabf_bench_pkg.sv
// ----------------------------------------------------------------------------
// kabf_bench_pkg
// Command codes shared by the filter testbench and its checker.
// ----------------------------------------------------------------------------
package kabf_bench_pkg;

    localparam logic CMD_UPDATE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // index past the register list, writes to it must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;

endpackage

FILE: bench/kabf_checker.sv
// ----------------------------------------------------------------------------
// kabf_checker
// Watches the input, output and register ports of the angle/bias Kalman
// filter, predicts every output word in fixed point and compares in order.
// ----------------------------------------------------------------------------
module kabf_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  kabf_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  kabf_pkg::t_out i_out_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [71:0] t_wide;

    localparam t_wide LIM64   = 72'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_wide LIM48   = 72'sh7FFF_FFFF_FFFF;
    localparam t_wide LIM32   = 72'sh7FFF_FFFF;
    localparam int    DT_FRAC = 28;
    localparam int    P_FRAC  = 32;

    logic [31:0]        q_angle_noise, q_bias_noise, r_noise;
    logic signed [31:0] angle_est, bias_est;
    logic signed [47:0] cov [4];
    kabf_pkg::t_out     expected_words [$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_words.size();

    function automatic t_wide clamp(t_wide x, t_wide lim);
        if (x > lim) return lim;
        if (x < -lim - 1) return -lim - 1;
        return x;
    endfunction

    // exact product, rounded half away from zero, clamped to 64 bits
    function automatic t_wide mul_round(t_wide a, t_wide b, int s);
        logic         neg;
        logic [143:0] x, y, p;
        neg = (a < 0) != (b < 0);
        x = {72'b0, (a < 0) ? -a : a};
        y = {72'b0, (b < 0) ? -b : b};
        p = ((x * y) + (144'd1 << (s - 1))) >> s;
        if (p > {72'b0, LIM64}) p = {72'b0, LIM64};
        return neg ? -t_wide'(p[71:0]) : t_wide'(p[71:0]);
    endfunction

    function automatic t_wide gain(t_wide num, t_wide den);
        logic [143:0] n, d, q, r;
        n = {72'b0, (num < 0) ? -num : num} << P_FRAC;
        d = {72'b0, den};
        q = n / d;
        r = n % d;
        if (q <= {72'b0, LIM48} && r >= d - r) q = q + 1;
        if (q > {72'b0, LIM48}) q = {72'b0, LIM48};
        return (num < 0) ? -t_wide'(q[71:0]) : t_wide'(q[71:0]);
    endfunction

    function automatic t_wide noise_cov(logic [31:0] v);
        return t_wide'({40'b0, v}) <<< (P_FRAC - DT_FRAC);
    endfunction

    task automatic filter_step(input kabf_pkg::t_in w);
        t_wide dt, p00, p01, p10, p11, dtp11, inner, s, k0, k1, y, ang;
        kabf_pkg::t_out res;
        if (w.command == kabf_bench_pkg::CMD_RESTART) begin
            angle_est = w.start_angle;
            bias_est  = '0;
            cov[0] = kabf_pkg::COV_ONE; cov[1] = '0; cov[2] = '0;
            cov[3] = kabf_pkg::COV_ONE;
        end else begin
            dt  = t_wide'({40'b0, w.time_step});
            p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
            ang = clamp(t_wide'(angle_est)
                  + mul_round(dt, t_wide'(w.turn_rate) - t_wide'(bias_est), DT_FRAC), LIM32);
            dtp11 = mul_round(dt, p11, DT_FRAC);
            inner = dtp11 - p01 - p10 + noise_cov(q_angle_noise);
            p00 = clamp(p00 + mul_round(dt, inner, DT_FRAC), LIM48);
            p01 = clamp(p01 - dtp11, LIM48);
            p10 = clamp(p10 - dtp11, LIM48);
            p11 = clamp(p11 + mul_round(noise_cov(q_bias_noise), dt, DT_FRAC), LIM48);
            s  = p00 + noise_cov(r_noise);
            k0 = '0;
            k1 = '0;
            if (s > 0) begin
                k0 = gain(p00, s);
                k1 = gain(p10, s);
            end
            y = t_wide'(w.meas_angle) - ang;
            angle_est = 32'(clamp(ang + mul_round(k0, y, P_FRAC), LIM32));
            bias_est  = 32'(clamp(t_wide'(bias_est) + mul_round(k1, y, P_FRAC), LIM32));
            cov[0] = 48'(clamp(p00 - mul_round(k0, p00, P_FRAC), LIM48));
            cov[1] = 48'(clamp(p01 - mul_round(k0, p01, P_FRAC), LIM48));
            cov[2] = 48'(clamp(p10 - mul_round(k1, p00, P_FRAC), LIM48));
            cov[3] = 48'(clamp(p11 - mul_round(k1, p01, P_FRAC), LIM48));
        end
        res.angle_estimate = angle_est;
        res.bias_estimate  = bias_est;
        expected_words.push_back(res);
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        kabf_pkg::t_out exp_w;
        if (!i_rst_n) begin
            q_angle_noise = 32'd268435;
            q_bias_noise  = 32'd805306;
            r_noise       = 32'd8053064;
            angle_est = '0;
            bias_est  = '0;
            cov[0] = kabf_pkg::COV_ONE; cov[1] = '0; cov[2] = '0;
            cov[3] = kabf_pkg::COV_ONE;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kabf_pkg::CFG_ANGLE_NOISE:   q_angle_noise = i_cfg_data;
                    kabf_pkg::CFG_BIAS_NOISE:    q_bias_noise  = i_cfg_data;
                    kabf_pkg::CFG_MEASURE_NOISE: r_noise       = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("output word with nothing expected");
                    fails++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (i_out_data.angle_estimate !== exp_w.angle_estimate) begin
                        $error("angle_estimate expected %h actual %h",
                               exp_w.angle_estimate, i_out_data.angle_estimate);
                        fails++;
                    end
                    if (i_out_data.bias_estimate !== exp_w.bias_estimate) begin
                        $error("bias_estimate expected %h actual %h",
                               exp_w.bias_estimate, i_out_data.bias_estimate);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) filter_step(i_in_data);
        end
    end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives update and restart words into the angle/bias Kalman filter with
// random gaps and back-pressure, under several noise register settings;
// the checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1350;
    localparam int LONG_HOLD    = 3000;

    logic           clk, rst_n;
    logic           in_valid, in_stall, out_valid, out_stall;
    kabf_pkg::t_in  in_data;
    kabf_pkg::t_out out_data;
    logic           cfg_we;
    logic [1:0]     cfg_idx;
    logic [31:0]    cfg_data;
    int             fail_count, pending;

    kalman_angle_bias_filter_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    kabf_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #8ms;
        $display("simulation failed");
        $finish;
    end

    // receiver: random hold per word, quiet stretches, one long hold
    initial begin
        int n, taken;
        bit quiet;
        out_stall = 1'b1;
        taken = 0;
        quiet = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken % 80 == 0) quiet = ($urandom_range(0, 2) == 0);
            n = quiet ? 0 : $urandom_range(0, 14);
            if (taken == 60) n = LONG_HOLD;
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    function automatic logic [31:0] signed_span(int unsigned lim);
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    function automatic kabf_pkg::t_in random_word();
        kabf_pkg::t_in w;
        w.command     = ($urandom_range(0, 24) == 0) ? kabf_bench_pkg::CMD_RESTART
                                                     : kabf_bench_pkg::CMD_UPDATE;
        w.start_angle = $urandom();
        if ($urandom_range(0, 9) == 0) begin
            w.meas_angle = $urandom();
            w.turn_rate  = $urandom();
            w.time_step  = $urandom();
        end else begin
            w.meas_angle = signed_span(180 << 16);
            w.turn_rate  = signed_span(500 << 16);
            w.time_step  = $urandom_range(0, 1 << 23);
        end
        return w;
    endfunction

    bit sending;

    task automatic send_word(input kabf_pkg::t_in w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0 && sending) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        sending = 1;
        do @(posedge clk); while (in_stall);
    endtask

    // sample the checker's queue away from the rising edge
    task automatic settle();
        if (sending) in_valid <= 1'b0;
        sending = 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] qa, qb, rm);
        write_reg(kabf_pkg::CFG_ANGLE_NOISE, qa);
        write_reg(kabf_pkg::CFG_BIAS_NOISE, qb);
        write_reg(kabf_pkg::CFG_MEASURE_NOISE, rm);
    endtask

    initial begin
        kabf_pkg::t_in w;
        int  per_phase;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        sending  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, both commands, default noise
        w = '0;
        send_word(w);
        w.time_step = 32'h1000_0000; w.turn_rate = 32'h0001_0000;
        w.meas_angle = 32'h0000_8000;
        send_word(w);
        w.meas_angle = 32'h7FFF_FFFF; w.turn_rate = 32'h7FFF_FFFF;
        w.time_step = 32'hFFFF_FFFF;
        send_word(w);
        w.meas_angle = 32'h8000_0000; w.turn_rate = 32'h8000_0000;
        send_word(w);
        send_word(w);
        w = '0; w.command = kabf_bench_pkg::CMD_RESTART; w.start_angle = 32'h7FFF_FFFF;
        w.meas_angle = 32'h1234_5678; w.time_step = 32'hFFFF_FFFF;
        send_word(w);
        w.start_angle = 32'h8000_0000;
        send_word(w);
        w.command = kabf_bench_pkg::CMD_UPDATE; w.meas_angle = 32'h7FFF_FFFF;
        w.turn_rate = 32'h8000_0000; w.time_step = 32'h0000_0001;
        send_word(w);
        settle();

        // measurement noise zero lets S reach zero or below
        write_all(32'd0, 32'd0, 32'd0);
        write_reg(kabf_bench_pkg::CFG_UNUSED, 32'hFFFF_FFFF);
        w = '0; w.command = kabf_bench_pkg::CMD_RESTART;
        send_word(w);
        w.command = kabf_bench_pkg::CMD_UPDATE; w.time_step = 32'hFFFF_FFFF;
        w.meas_angle = 32'h0010_0000;
        repeat (4) send_word(w);
        w.time_step = 32'h0400_0000; w.turn_rate = 32'hFFF0_0000;
        repeat (4) send_word(w);
        settle();

        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        w = '0; w.time_step = 32'h0100_0000; w.meas_angle = 32'h0005_0000;
        repeat (3) send_word(w);
        w.time_step = 32'hFFFF_FFFF;
        send_word(w);
        settle();

        // random phases under varied noise settings
        per_phase = RANDOM_WORDS / 5;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_all(32'd268435, 32'd805306, 32'd8053064);
                1: write_all(32'd0, 32'd0, 32'd0);
                2: write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: write_all($urandom(), $urandom_range(0, 1 << 24), $urandom());
            endcase
            w = '0; w.command = kabf_bench_pkg::CMD_RESTART;
            w.start_angle = signed_span(90 << 16);
            send_word(w);
            for (int i = 0; i < per_phase; i++) send_word(random_word());
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
